### hdl/bmst_pkg.sv
`timescale 1ns / 1ps

package bmst_pkg;

  // Size of the value store and the widths that follow from it.
  localparam int MAX_ENTRIES   = 64;
  localparam int ADDR_W        = $clog2(MAX_ENTRIES);
  localparam int CNT_W         = $clog2(MAX_ENTRIES + 1);
  localparam int DATA_W        = 32;
  localparam int MIN_FOR_SPANS = 2;

  // Flipping the sign bit makes unsigned order match signed order.
  localparam logic [DATA_W-1:0] SIGN_BIAS = {1'b1, {(DATA_W-1){1'b0}}};

  // Configuration port.
  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 2;
  localparam logic [PADDR_W-1:0] CAPACITY_ADDR  = '0;
  localparam logic [CNT_W-1:0]   CAPACITY_RESET = CNT_W'(MAX_ENTRIES);

  // Request opcodes.
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic              op;
    logic [DATA_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic              accepted;
    logic [CNT_W-1:0]  count;
    logic              spans_valid;
    logic [DATA_W-1:0] shortest;
    logic [DATA_W-1:0] longest;
  } result_t;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_WALK   = 7'b0000010,
    S_PLACE  = 7'b0000100,
    S_GAP_LO = 7'b0001000,
    S_GAP_HI = 7'b0010000,
    S_SPAN   = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

endpackage

### hdl/bmst_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module bmst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/bounded_multiset_span_tracker_core.sv
`timescale 1ns / 1ps

// Bounded multiset span tracker.
//
// The block keeps up to "capacity" signed 32-bit values in ascending order.
// Each request on the item channel either adds its value or clears the set,
// and produces exactly one result request carrying the accept flag, the
// count, and (with two or more values held) the smallest neighbor gap and
// the range from the smallest to the largest value.
//
// Both channels use valid/stall; a request moves at a clock edge where
// valid is high and stall is low. The block works on one request at a time
// and holds item_stall high while busy. A clear, or an add refused because
// the set is full, passes through S_SPAN and S_FINISH before raising
// result_valid. An add of a value that lands at position p in a set of n
// values moves the n - p values above it up one place in the insertion
// walk, one stored value per cycle through the single RAM write port.
//
// A synchronous reset empties the set and restores capacity to 64; no
// clearing pass over the store is needed. If the receiver stalls, the
// finished result waits in the output register and the block holds the
// next result back until the waiting one is taken.
module bounded_multiset_span_tracker_core
  import bmst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Item channel.
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  // Result channel.
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  state_t            state;
  logic [CNT_W-1:0]  capacity;
  logic [CNT_W-1:0]  held_count;
  logic [DATA_W-1:0] smallest_gap;

  // Working registers for the request in flight. Stored values are biased.
  logic [DATA_W-1:0] v;
  logic [ADDR_W-1:0] idx;
  logic [DATA_W-1:0] nb_lo;
  logic [DATA_W-1:0] nb_hi;
  logic              have_lo;
  logic              have_hi;
  logic [DATA_W-1:0] vmin;
  logic [DATA_W-1:0] vmax;
  logic [DATA_W-1:0] span;
  logic              accepted;

  logic              item_accept;
  logic [CNT_W-1:0]  limit;
  logic              room;
  logic [CNT_W-1:0]  count_m1;
  logic              result_load;

  logic [DATA_W-1:0] alu_a;
  logic [DATA_W-1:0] alu_b;
  logic [DATA_W:0]   alu_diff;
  logic              alu_borrow;
  logic [DATA_W-1:0] alu_res;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic              spans_ok;

  // The configuration port is always ready; capacity is its only register.
  assign pready = 1'b1;
  assign prdata = (paddr == CAPACITY_ADDR) ? APB_DATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (psel && penable && pwrite && (paddr == CAPACITY_ADDR)) begin
      capacity <= pwdata[CNT_W-1:0];
    end
  end

  // A capacity above the store size saturates at the store size.
  assign limit = (capacity > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : capacity;
  assign room  = held_count < limit;
  assign count_m1 = held_count - CNT_W'(1);

  assign item_stall  = (state != S_IDLE);
  assign item_accept = item_valid && !item_stall;

  // A finished result moves to the output register once that register is
  // empty or is being emptied at the same edge.
  assign result_load = (state == S_FINISH) && (!result_valid || !result_stall);

  // The one subtractor shared by the walk, gap and span steps. Its borrow doubles as the
  // "greater than" compare during the insertion walk.
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    unique case (state)
      S_WALK: begin
        alu_a = v;
        alu_b = ram_rdata;
      end
      S_GAP_LO: begin
        alu_a = v;
        alu_b = nb_lo;
      end
      S_GAP_HI: begin
        alu_a = nb_hi;
        alu_b = v;
      end
      S_SPAN: begin
        alu_a = vmax;
        alu_b = vmin;
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  assign alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_borrow = alu_diff[DATA_W];
  assign alu_res    = alu_diff[DATA_W-1:0];

  // Store control. The walk starts at the top entry and moves each entry
  // greater than the new value up by one, reading the next lower entry in
  // the same cycle. The first entry not greater than the new value stops
  // the walk, and the new value goes just above it.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = v;
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (state)
      S_IDLE: begin
        if (item_accept && (item.op == OP_ADD) && room && (held_count != '0)) begin
          ram_re    = 1'b1;
          ram_raddr = count_m1[ADDR_W-1:0];
        end
      end
      S_WALK: begin
        ram_we    = 1'b1;
        ram_waddr = idx + ADDR_W'(1);
        ram_wdata = alu_borrow ? ram_rdata : v;
        if (alu_borrow && (idx != '0)) begin
          ram_re    = 1'b1;
          ram_raddr = idx - ADDR_W'(1);
        end
      end
      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = v;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  bmst_ram #(
    .WIDTH(DATA_W),
    .DEPTH(MAX_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign spans_ok = held_count >= CNT_W'(MIN_FOR_SPANS);

  // Sequencer. The smallest gap is kept up to date incrementally: a new
  // value can only shrink it, through the gaps to its two neighbors.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      held_count   <= '0;
      smallest_gap <= '1;
      result_valid <= 1'b0;
    end else begin
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_accept) begin
            if (item.op == OP_CLEAR) begin
              held_count   <= '0;
              smallest_gap <= '1;
              accepted     <= 1'b1;
              state        <= S_SPAN;
            end else if (!room) begin
              accepted <= 1'b0;
              state    <= S_SPAN;
            end else begin
              accepted <= 1'b1;
              v        <= item.value ^ SIGN_BIAS;
              have_lo  <= 1'b0;
              have_hi  <= 1'b0;
              if (held_count == '0) begin
                state <= S_PLACE;
              end else begin
                idx   <= count_m1[ADDR_W-1:0];
                state <= S_WALK;
              end
            end
          end
        end
        S_WALK: begin
          if (alu_borrow) begin
            nb_hi   <= ram_rdata;
            have_hi <= 1'b1;
            if (idx == '0) begin
              state <= S_PLACE;
            end else begin
              idx <= idx - ADDR_W'(1);
            end
          end else begin
            nb_lo      <= ram_rdata;
            have_lo    <= 1'b1;
            held_count <= held_count + CNT_W'(1);
            state      <= S_GAP_LO;
          end
        end
        S_PLACE: begin
          held_count <= held_count + CNT_W'(1);
          state      <= S_GAP_LO;
        end
        S_GAP_LO: begin
          if (have_lo) begin
            if (alu_res < smallest_gap) begin
              smallest_gap <= alu_res;
            end
          end else begin
            vmin <= v;
          end
          state <= S_GAP_HI;
        end
        S_GAP_HI: begin
          if (have_hi) begin
            if (alu_res < smallest_gap) begin
              smallest_gap <= alu_res;
            end
          end else begin
            vmax <= v;
          end
          state <= S_SPAN;
        end
        S_SPAN: begin
          span  <= alu_res;
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (result_load) begin
            result.accepted    <= accepted;
            result.count       <= held_count;
            result.spans_valid <= spans_ok;
            result.shortest    <= spans_ok ? smallest_gap : '0;
            result.longest     <= spans_ok ? span : '0;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/bmst_checker.sv
`timescale 1ns / 1ps

module bmst_checker
  import bmst_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // A stalled result stays offered.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  // A stalled result does not change.
  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result))
    else $error("result changed while stalled");

  // The block works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("item accepted while a request is in flight");

  // The count never exceeds the store, and spans are reported exactly when
  // two or more values are held.
  a_count_spans: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.count <= CNT_W'(MAX_ENTRIES)) &&
                     (result.spans_valid == (result.count >= CNT_W'(MIN_FOR_SPANS))))
    else $error("count or spans flag inconsistent");

  // Without spans, both span fields read zero.
  a_spans_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.spans_valid |-> (result.shortest == '0) &&
                                            (result.longest == '0))
    else $error("span fields nonzero with fewer than two values");

endmodule

bind bounded_multiset_span_tracker_core bmst_checker u_bmst_checker (.*);
